>>> design/ofa_pkg.sv
// Shared types and constants for the optical flow frame accumulator.
// Used by the front end, the transfer queue, the back end and the checker.
package ofa_pkg;

  localparam int FRAME_LEN = 9;
  localparam int STORE_LEN = 8;
  localparam logic [7:0] HEADER_BYTE = 8'hFE;
  localparam logic [7:0] TRAILER_BYTE = 8'hAA;
  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [7:0] QUALITY_RESET = 8'd30;

  localparam logic [2:0] ST_APPLIED = 3'd0;
  localparam logic [2:0] ST_LENGTH = 3'd1;
  localparam logic [2:0] ST_FRAMING = 3'd2;
  localparam logic [2:0] ST_CHECKSUM = 3'd3;
  localparam logic [2:0] ST_QUALITY = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } job_t;

endpackage

>>> design/ofa_front.sv
// Front end: collects frame bytes, checks a frame at its last byte and
// turns frame ends and clear commands into jobs. Depends on ofa_pkg.
module ofa_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    min_quality,
  input  logic          in_valid,
  input  logic          in_cmd,
  input  logic [7:0]    in_byte,
  input  logic          in_eof,
  output logic          in_ready,
  input  logic          job_ready,
  output logic          job_valid,
  output ofa_pkg::job_t job
);

  logic [3:0] byte_count_r, byte_count_nxt;
  logic [7:0] store_r [ofa_pkg::STORE_LEN];
  logic       take;
  logic [7:0] sum;

  assign in_ready = job_ready;
  assign take = in_valid && in_ready;
  assign job_valid = take && (in_cmd || in_eof);
  assign sum = store_r[2] + store_r[3] + store_r[4] + store_r[5];

  always_comb begin
    job.raw_x = {store_r[3], store_r[2]};
    job.raw_y = {store_r[5], store_r[4]};
    if (in_cmd) begin
      job.status = ofa_pkg::ST_CLEARED;
    end else if (byte_count_r != 4'(ofa_pkg::FRAME_LEN - 1)) begin
      job.status = ofa_pkg::ST_LENGTH;
    end else if (store_r[0] != ofa_pkg::HEADER_BYTE || in_byte != ofa_pkg::TRAILER_BYTE) begin
      job.status = ofa_pkg::ST_FRAMING;
    end else if (sum != store_r[6]) begin
      job.status = ofa_pkg::ST_CHECKSUM;
    end else if (store_r[7] <= min_quality) begin
      job.status = ofa_pkg::ST_QUALITY;
    end else begin
      job.status = ofa_pkg::ST_APPLIED;
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (take && !in_cmd) begin
      if (in_eof) begin
        byte_count_nxt = 4'd0;
      end else if (byte_count_r != ofa_pkg::COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 4'd0;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !in_cmd && byte_count_r < 4'(ofa_pkg::STORE_LEN)) begin
      store_r[byte_count_r[2:0]] <= in_byte;
    end
  end

endmodule

>>> design/ofa_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on ofa_pkg for the job type.
module ofa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ofa_pkg::job_t push_job,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output ofa_pkg::job_t head
);

  ofa_pkg::job_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign not_full = count_r != 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> design/ofa_back.sv
// Back end: applies jobs to the velocity and position registers and holds
// the result in an output register. Depends on ofa_pkg.
module ofa_back #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  ofa_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [16:0]   out_vel_x,
  output logic [15:0]   out_vel_y,
  output logic [31:0]   out_pos_x,
  output logic [31:0]   out_pos_y
);

  logic [16:0] vel_x_r, vel_x_nxt;
  logic [15:0] vel_y_r, vel_y_nxt;
  logic [POSITION_WIDTH-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [POSITION_WIDTH+31:0] ext_x, ext_y;
  logic out_valid_r;
  logic [2:0] status_r;
  logic [16:0] ovx_r;
  logic [15:0] ovy_r;
  logic [31:0] opx_r, opy_r;

  assign job_pop = job_valid && (!out_valid_r || out_ready);

  always_comb begin
    vel_x_nxt = vel_x_r;
    vel_y_nxt = vel_y_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (job.status == ofa_pkg::ST_CLEARED) begin
      pos_x_nxt = '0;
      pos_y_nxt = '0;
    end else if (job.status == ofa_pkg::ST_APPLIED) begin
      vel_x_nxt = 17'd0 - 17'($signed(job.raw_x));
      vel_y_nxt = job.raw_y;
      pos_x_nxt = pos_x_r + POSITION_WIDTH'($signed(vel_x_nxt));
      pos_y_nxt = pos_y_r + POSITION_WIDTH'($signed(vel_y_nxt));
    end
  end

  assign ext_x = {32'd0, pos_x_nxt};
  assign ext_y = {32'd0, pos_y_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_x_r <= '0;
      vel_y_r <= '0;
      pos_x_r <= '0;
      pos_y_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_pop) begin
        vel_x_r <= vel_x_nxt;
        vel_y_r <= vel_y_nxt;
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      status_r <= job.status;
      ovx_r <= vel_x_nxt;
      ovy_r <= vel_y_nxt;
      opx_r <= ext_x[31:0];
      opy_r <= ext_y[31:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_vel_x = ovx_r;
  assign out_vel_y = ovy_r;
  assign out_pos_x = opx_r;
  assign out_pos_y = opy_r;

endmodule

>>> design/optical_flow_frame_accumulator_unit.sv
// Top level of the optical flow frame accumulator.
// Instantiates ofa_front, ofa_queue and ofa_back; depends on ofa_pkg.
//
// Usage:
// The input stream carries one received sensor byte per transfer in in_tdata,
// with in_tlast on the last byte of a frame (line idle) and in_tuser set for
// a clear-position command. A nine-byte frame is checked at its last byte:
// length, header and trailer, checksum of bytes 2..5 against byte 6, and the
// quality byte against the min_quality register written through cfg_wr_en.
// Every frame end and every clear gives one result transfer on the output
// stream: status in out_tuser, velocity and position in out_tdata.
// Bytes inside a frame give no result.
// A job is queued when its input transfer is taken and is loaded into the
// output register when the back end pops it. The block takes one input
// transfer per cycle while the job queue has room; the two-entry job queue and
// the output register let it keep accepting while a result waits.
// When the receiver stalls, the result holds and the queue fills; in_tready
// falls once the queue is full. Reset clears the byte count, velocity,
// position and queue and sets min_quality to 30.
module optical_flow_frame_accumulator_unit #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_frame
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [ofa_pkg::OUT_DATA_W-1:0] out_tdata, // velocity_x, velocity_y,
                                                    // position_x, position_y, zero pad
  output logic [2:0]  out_tuser   // [2:0] status
);

  logic [7:0] min_quality_r;
  logic job_push, q_not_full, q_not_empty, q_pop;
  ofa_pkg::job_t push_job, head_job;
  logic [16:0] vel_x;
  logic [15:0] vel_y;
  logic [31:0] pos_x, pos_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_quality_r <= ofa_pkg::QUALITY_RESET;
    end else if (cfg_wr_en) begin
      min_quality_r <= cfg_wr_data;
    end
  end

  ofa_front u_front (
    .clk(clk), .rst_n(rst_n), .min_quality(min_quality_r),
    .in_valid(in_tvalid), .in_cmd(in_tuser), .in_byte(in_tdata), .in_eof(in_tlast),
    .in_ready(in_tready), .job_ready(q_not_full), .job_valid(job_push), .job(push_job)
  );

  ofa_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(job_push), .push_job(push_job),
    .not_full(q_not_full), .pop(q_pop), .not_empty(q_not_empty), .head(head_job)
  );

  ofa_back #(.POSITION_WIDTH(POSITION_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_not_empty), .job(head_job), .job_pop(q_pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_status(out_tuser),
    .out_vel_x(vel_x), .out_vel_y(vel_y), .out_pos_x(pos_x), .out_pos_y(pos_y)
  );

  assign out_tdata = {7'd0, pos_y, pos_x, vel_y, vel_x};

endmodule

>>> design/ofa_checker.sv
// Port-level checks for the optical flow frame accumulator.
// Depends on ofa_pkg; bound to optical_flow_frame_accumulator_unit below.
module ofa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [ofa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ofa_pkg::ST_CLEARED)
    else $error("Result status out of range.");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ofa_pkg::ST_CLEARED |-> out_tdata[96:33] == 64'd0)
    else $error("Clear result shows a nonzero position.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled result transfer changed.");

  a_mid_frame_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && !in_tuser && !out_tvalid
      |=> ##1 !out_tvalid || $past(out_tvalid) || $past(in_tvalid && in_tready, 1))
    else $error("Result appeared for a byte inside a frame.");

endmodule

bind optical_flow_frame_accumulator_unit ofa_checker u_ofa_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .in_tuser(in_tuser), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);
